// File: design/pafk_pkg.sv
// Package for the planar arm forward kinematics block: widths, constants and the sine table.
`default_nettype none
package pafk_pkg;

	localparam int ANGLE_STEPS = 1024;
	localparam int ANGLE_W = $clog2(ANGLE_STEPS);
	localparam int QUARTER_TURN = ANGLE_STEPS / 4;
	localparam int MAX_ARMS = 6;

	localparam int JOINT_ANGLE_W = 10;
	localparam int SEG_W = 3;
	localparam int COORD_W = 25;
	localparam int SINE_W = 18;
	localparam int ARM_LEN_W = 22;
	localparam int NUM_ARMS_W = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 22;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 104;

	localparam logic [CFG_INDEX_W-1:0] REG_ARM_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUM_ARMS = 1'd1;

	localparam logic [ARM_LEN_W-1:0] ARM_LENGTH_RESET = 22'd209715;
	localparam logic [NUM_ARMS_W-1:0] NUM_ARMS_RESET = 3'd3;

	localparam logic [63:0] Q62_ONE = 64'h4000000000000000;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef logic signed [SINE_W-1:0] sine_tab_t [ANGLE_STEPS];

	// Fixed-point product (a * b) >> 62, kept to 64 bits.
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// Taylor series of sin((pi/2) * t) for t in Q62 within [0, 1].
	// Term k is divided by (2k) * (2k + 1), with alternating signs.
	function automatic logic [63:0] quarter_sin(input logic [63:0] t);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] term;
		logic [63:0] sum;
		u = mul_q62(t, HALF_PI_Q62);
		u2 = mul_q62(u, u);
		term = u;
		sum = u;
		term = mul_q62(term, u2) / 64'd6;
		sum = sum - term;
		term = mul_q62(term, u2) / 64'd20;
		sum = sum + term;
		term = mul_q62(term, u2) / 64'd42;
		sum = sum - term;
		term = mul_q62(term, u2) / 64'd72;
		sum = sum + term;
		term = mul_q62(term, u2) / 64'd110;
		sum = sum - term;
		term = mul_q62(term, u2) / 64'd156;
		sum = sum + term;
		term = mul_q62(term, u2) / 64'd210;
		sum = sum - term;
		term = mul_q62(term, u2) / 64'd272;
		sum = sum + term;
		term = mul_q62(term, u2) / 64'd342;
		sum = sum - term;
		term = mul_q62(term, u2) / 64'd420;
		sum = sum + term;
		term = mul_q62(term, u2) / 64'd506;
		sum = sum - term;
		term = mul_q62(term, u2) / 64'd600;
		sum = sum + term;
		return sum;
	endfunction

	// Builds round(65536 * sin(2 * pi * i / ANGLE_STEPS)) for every entry.
	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] hi;
		logic [63:0] r2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		for (int i = 0; i < ANGLE_STEPS; i++) begin
			q = 64'((4 * i) / ANGLE_STEPS);
			rem = 64'((4 * i) % ANGLE_STEPS);
			hi = (rem << 50) / ANGLE_STEPS;
			r2 = (rem << 50) % ANGLE_STEPS;
			t = (hi << 12) + ((r2 << 12) / ANGLE_STEPS);
			if (q[0]) begin
				t = Q62_ONE - t;
			end
			s = quarter_sin(t);
			v = (s + (64'd1 << 45)) >> 46;
			if (q[1]) begin
				tab[i] = -$signed(v[SINE_W-1:0]);
			end else begin
				tab[i] = $signed(v[SINE_W-1:0]);
			end
		end
		return tab;
	endfunction

endpackage
`default_nettype wire

// File: design/planar_arm_forward_kinematics.sv
// Top level of the planar arm forward kinematics block.
//
// Each input item carries one relative joint angle in s_tdata[9:0], in 1/1024 turn.
// Each item gives exactly one output item: one arm segment with its index, start
// point and end point, and m_tlast set on the tip segment of the arm.
// The cfg port writes arm_length (index 0) and num_arms (index 1); write it only
// while no item is in flight.
// An accepted item sits in the input register, where the sine and cosine are
// looked up, and is then rotated and written to the output register, from which
// it drives m_tdata.
// The block takes one item per cycle unless the receiver stalls. The end point
// of a segment feeds the next through a register loop around the rotate logic.
// When the receiver stalls, the output register holds its item and the input
// register can still take one more item; s_tready then falls.
// Reset clears the valid flags of both registers, sets arm_length and num_arms to
// 209715 and 3, and starts a new arm at the origin.
`default_nettype none
module planar_arm_forward_kinematics (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// Fields from bit 0: joint_angle[9:0], zero fill.
	input  wire logic [pafk_pkg::S_TDATA_W-1:0]       s_tdata,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// Fields from bit 0: segment_index, start_x, start_y, end_x, end_y, zero fill.
	output logic [pafk_pkg::M_TDATA_W-1:0]            m_tdata,
	output logic                                      m_tlast,
	input  wire logic                                 cfg_we,
	input  wire logic [pafk_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [pafk_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pafk_pkg::*;

	localparam sine_tab_t SINE_TAB = build_sine_tab();
	localparam int PACK_W = SEG_W + 4 * COORD_W;

	logic [ARM_LEN_W-1:0]       arm_length_q;
	logic [NUM_ARMS_W-1:0]      num_arms_q;
	logic                       valid_s1;
	logic signed [SINE_W-1:0]   sin_s1;
	logic signed [SINE_W-1:0]   cos_s1;
	logic signed [COORD_W-1:0]  base_x_q;
	logic signed [COORD_W-1:0]  base_y_q;
	logic signed [COORD_W-1:0]  joint_x_q;
	logic signed [COORD_W-1:0]  joint_y_q;
	logic [SEG_W-1:0]           seg_count_q;
	logic                       out_valid_q;
	logic [SEG_W-1:0]           out_seg_q;
	logic signed [COORD_W-1:0]  out_sx_q;
	logic signed [COORD_W-1:0]  out_sy_q;
	logic signed [COORD_W-1:0]  out_ex_q;
	logic signed [COORD_W-1:0]  out_ey_q;
	logic                       out_last_q;

	logic [ANGLE_W-1:0]         sin_idx;
	logic [ANGLE_W-1:0]         cos_idx;
	logic                       advance;
	logic                       accept_in;
	logic signed [COORD_W-1:0]  start_x;
	logic signed [COORD_W-1:0]  start_y;
	logic signed [COORD_W-1:0]  back_x;
	logic signed [COORD_W-1:0]  back_y;
	logic signed [COORD_W-1:0]  end_x;
	logic signed [COORD_W-1:0]  end_y;
	logic [SEG_W-1:0]           arms_eff;
	logic [SEG_W:0]             seg_next;
	logic                       last_seg;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept_in = s_tvalid && s_tready;

	assign sin_idx = s_tdata[ANGLE_W-1:0];
	assign cos_idx = sin_idx + ANGLE_W'(QUARTER_TURN);

	always_comb begin
		if (num_arms_q == '0) begin
			arms_eff = SEG_W'(1);
		end else if (num_arms_q > SEG_W'(MAX_ARMS)) begin
			arms_eff = SEG_W'(MAX_ARMS);
		end else begin
			arms_eff = num_arms_q;
		end
		seg_next = {1'b0, seg_count_q} + 1'b1;
		last_seg = seg_next >= {1'b0, arms_eff};
		if (seg_count_q == '0) begin
			start_x = '0;
			start_y = '0;
			back_x = '0;
			back_y = -$signed({{(COORD_W - ARM_LEN_W){1'b0}}, arm_length_q});
		end else begin
			start_x = joint_x_q;
			start_y = joint_y_q;
			back_x = base_x_q;
			back_y = base_y_q;
		end
	end

	pafk_rotate u_rotate (
		.start_x (start_x),
		.start_y (start_y),
		.back_x  (back_x),
		.back_y  (back_y),
		.sin_v   (sin_s1),
		.cos_v   (cos_s1),
		.end_x   (end_x),
		.end_y   (end_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_length_q <= ARM_LENGTH_RESET;
			num_arms_q <= NUM_ARMS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARM_LENGTH: arm_length_q <= cfg_data[ARM_LEN_W-1:0];
				REG_NUM_ARMS: num_arms_q <= cfg_data[NUM_ARMS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			sin_s1 <= SINE_TAB[sin_idx];
			cos_s1 <= SINE_TAB[cos_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0;
			base_y_q <= '0;
			joint_x_q <= '0;
			joint_y_q <= '0;
			seg_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				base_x_q <= start_x;
				base_y_q <= start_y;
				joint_x_q <= end_x;
				joint_y_q <= end_y;
				seg_count_q <= last_seg ? '0 : seg_next[SEG_W-1:0];
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_seg_q <= seg_count_q;
			out_sx_q <= start_x;
			out_sy_q <= start_y;
			out_ex_q <= end_x;
			out_ey_q <= end_y;
			out_last_q <= last_seg;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {{(M_TDATA_W - PACK_W){1'b0}}, out_ey_q, out_ex_q, out_sy_q, out_sx_q,
		out_seg_q};

	a_seg_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		seg_count_q < SEG_W'(MAX_ARMS))
		else $error("Segment counter left the arm.");

	a_base_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_seg_q == '0) |-> (out_sx_q == '0 && out_sy_q == '0))
		else $error("First segment does not start at the origin.");

	a_chain_links: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && seg_count_q != '0) |-> (start_x == joint_x_q && start_y == joint_y_q))
		else $error("Segment start is not the previous segment end.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !advance)
		else $error("Stalled output item was overwritten.");

endmodule
`default_nettype wire

// File: design/pafk_rotate.sv
// Rotation of the back vector about the segment start, with rounding and saturation.
`default_nettype none
module pafk_rotate (
	input  wire logic signed [pafk_pkg::COORD_W-1:0] start_x,
	input  wire logic signed [pafk_pkg::COORD_W-1:0] start_y,
	input  wire logic signed [pafk_pkg::COORD_W-1:0] back_x,
	input  wire logic signed [pafk_pkg::COORD_W-1:0] back_y,
	input  wire logic signed [pafk_pkg::SINE_W-1:0]  sin_v,
	input  wire logic signed [pafk_pkg::SINE_W-1:0]  cos_v,
	output logic signed [pafk_pkg::COORD_W-1:0]      end_x,
	output logic signed [pafk_pkg::COORD_W-1:0]      end_y
);
	import pafk_pkg::*;

	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = DIFF_W + SINE_W;
	localparam int ACC_W = PROD_W + 1;
	localparam int RND_W = ACC_W - 16;
	localparam int SUM_W = RND_W + 1;
	localparam logic signed [SUM_W-1:0] COORD_MAX = SUM_W'((64'sd1 <<< (COORD_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] COORD_MIN = -SUM_W'(64'sd1 <<< (COORD_W - 1));

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic signed [PROD_W-1:0] p_xc;
	logic signed [PROD_W-1:0] p_ys;
	logic signed [PROD_W-1:0] p_xs;
	logic signed [PROD_W-1:0] p_yc;
	logic signed [ACC_W-1:0]  acc_x;
	logic signed [ACC_W-1:0]  acc_y;
	logic signed [RND_W-1:0]  rnd_x;
	logic signed [RND_W-1:0]  rnd_y;
	logic signed [SUM_W-1:0]  sum_x;
	logic signed [SUM_W-1:0]  sum_y;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		if (v > COORD_MAX) begin
			return COORD_MAX[COORD_W-1:0];
		end else if (v < COORD_MIN) begin
			return COORD_MIN[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

	always_comb begin
		dx = $signed({back_x[COORD_W-1], back_x}) - $signed({start_x[COORD_W-1], start_x});
		dy = $signed({back_y[COORD_W-1], back_y}) - $signed({start_y[COORD_W-1], start_y});
		p_xc = dx * cos_v;
		p_ys = dy * sin_v;
		p_xs = dx * sin_v;
		p_yc = dy * cos_v;
		// Round to nearest with halves going up, then drop the 16 extra fraction bits.
		acc_x = ACC_W'(p_xc) - ACC_W'(p_ys) + ACC_W'(32768);
		acc_y = ACC_W'(p_xs) + ACC_W'(p_yc) + ACC_W'(32768);
		rnd_x = acc_x[ACC_W-1:16];
		rnd_y = acc_y[ACC_W-1:16];
		sum_x = SUM_W'(rnd_x) + SUM_W'(start_x);
		sum_y = SUM_W'(rnd_y) + SUM_W'(start_y);
		end_x = sat_coord(sum_x);
		end_y = sat_coord(sum_y);
	end

endmodule
`default_nettype wire

// File: test/planar_arm_forward_kinematics_tb.sv
`timescale 1ns / 1ps
// Testbench for the planar arm forward kinematics block: directed angles, then random phases.
module planar_arm_forward_kinematics_tb;
	import pafk_pkg::*;

	localparam int SX_LSB = SEG_W;
	localparam int SY_LSB = SX_LSB + COORD_W;
	localparam int EX_LSB = SY_LSB + COORD_W;
	localparam int EY_LSB = EX_LSB + COORD_W;
	localparam longint COORD_HI = 16777215;
	localparam longint COORD_LO = -16777216;
	localparam longint ROUND_HALF = 32768;
	localparam int FRAC_SHIFT = 16;
	localparam real TWO_PI = 6.283185307179586;
	localparam int L0 = int'(ARM_LENGTH_RESET);
	localparam int N_DIR = 21;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic last;
	} segment_t;

	typedef struct packed {
		logic [JOINT_ANGLE_W-1:0] angle;
		logic typed;
		segment_t want;
	} dir_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// The first four rows start from reset and can be worked out by hand.
	dir_row_t dir_rows [N_DIR] = '{
		'{10'd0, 1'b1, '{3'd0, 0, 0, 0, -L0, 1'b0}},
		'{10'd0, 1'b1, '{3'd1, 0, -L0, 0, 0, 1'b0}},
		'{10'd512, 1'b1, '{3'd2, 0, 0, 0, L0, 1'b1}},
		'{10'd256, 1'b1, '{3'd0, 0, 0, L0, 0, 1'b0}},
		'{10'd1023, 1'b0, '0},
		'{10'd1, 1'b0, '0},
		'{10'd768, 1'b0, '0},
		'{10'd255, 1'b0, '0},
		'{10'd257, 1'b0, '0},
		'{10'd511, 1'b0, '0},
		'{10'd513, 1'b0, '0},
		'{10'd767, 1'b0, '0},
		'{10'd769, 1'b0, '0},
		'{10'd1022, 1'b0, '0},
		'{10'd128, 1'b0, '0},
		'{10'd384, 1'b0, '0},
		'{10'd640, 1'b0, '0},
		'{10'd896, 1'b0, '0},
		'{10'd2, 1'b0, '0},
		'{10'd341, 1'b0, '0},
		'{10'd682, 1'b0, '0}
	};

	segment_t pending_segments [$];
	int sine_q16 [ANGLE_STEPS];
	logic [ARM_LEN_W-1:0] arm_len_m;
	logic [NUM_ARMS_W-1:0] arms_m;
	longint base_xm;
	longint base_ym;
	longint tip_xm;
	longint tip_ym;
	int seg_next;
	int n_items = 0;
	int n_results = 0;
	int n_tips = 0;
	int n_sat = 0;
	int n_errors = 0;
	int n_settings = 1;
	bit calm = 1'b0;
	int rx_hold = 0;

	planar_arm_forward_kinematics uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic string fmt_segment(input segment_t s);
		return $sformatf("seg %0d start (%0d, %0d) end (%0d, %0d) last %0b",
			s.seg, s.sx, s.sy, s.ex, s.ey, s.last);
	endfunction

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_HI) begin
			return COORD_HI;
		end
		if (v < COORD_LO) begin
			return COORD_LO;
		end
		return v;
	endfunction

	// Rotates the back vector about the current joint and moves the arm one segment on.
	function automatic segment_t advance_arm(input logic [JOINT_ANGLE_W-1:0] angle);
		segment_t r;
		logic [ANGLE_W-1:0] cidx;
		longint sn, cs, sx, sy, px, py, dx, dy, ex_raw, ey_raw, ex, ey;
		int n;
		cidx = ANGLE_W'(angle + QUARTER_TURN);
		sn = sine_q16[angle];
		cs = sine_q16[cidx];
		n = arms_m;
		if (n < 1) begin
			n = 1;
		end
		if (n > MAX_ARMS) begin
			n = MAX_ARMS;
		end
		if (seg_next == 0) begin
			sx = 0;
			sy = 0;
			px = 0;
			py = -longint'(arm_len_m);
		end else begin
			sx = tip_xm;
			sy = tip_ym;
			px = base_xm;
			py = base_ym;
		end
		dx = px - sx;
		dy = py - sy;
		ex_raw = sx + ((dx * cs - dy * sn + ROUND_HALF) >>> FRAC_SHIFT);
		ey_raw = sy + ((dx * sn + dy * cs + ROUND_HALF) >>> FRAC_SHIFT);
		ex = clamp_coord(ex_raw);
		ey = clamp_coord(ey_raw);
		if (ex != ex_raw || ey != ey_raw) begin
			n_sat++;
		end
		r.seg = SEG_W'(seg_next);
		r.sx = sx[COORD_W-1:0];
		r.sy = sy[COORD_W-1:0];
		r.ex = ex[COORD_W-1:0];
		r.ey = ey[COORD_W-1:0];
		r.last = (seg_next + 1 >= n);
		base_xm = sx;
		base_ym = sy;
		tip_xm = ex;
		tip_ym = ey;
		seg_next = r.last ? 0 : seg_next + 1;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Straight mode keeps the arm nearly stretched so that long segments run off the range.
	function automatic logic [JOINT_ANGLE_W-1:0] pick_angle(input bit straight);
		int r;
		r = $urandom_range(0, 99);
		if (straight && r < 70) begin
			return JOINT_ANGLE_W'(504 + $urandom_range(0, 16));
		end
		if (r < 15) begin
			case ($urandom_range(0, 5))
				0: begin
					return '0;
				end
				1: begin
					return '1;
				end
				2: begin
					return JOINT_ANGLE_W'(QUARTER_TURN);
				end
				3: begin
					return JOINT_ANGLE_W'(2 * QUARTER_TURN);
				end
				4: begin
					return JOINT_ANGLE_W'(3 * QUARTER_TURN);
				end
				default: begin
					return JOINT_ANGLE_W'(1);
				end
			endcase
		end
		return JOINT_ANGLE_W'($urandom_range(0, ANGLE_STEPS - 1));
	endfunction

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= MAX_SHOWN) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	task automatic send_joint(input logic [JOINT_ANGLE_W-1:0] angle, input bit typed,
			input segment_t want);
		int gap;
		segment_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'(angle);
		do @(posedge clk); while (!s_tready);
		pred = advance_arm(angle);
		pending_segments.insert(pending_segments.size(), typed ? want : pred);
		n_items++;
	endtask

	task automatic set_arm(input logic [ARM_LEN_W-1:0] len, input logic [NUM_ARMS_W-1:0] arms);
		while (pending_segments.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_ARM_LENGTH;
		cfg_data <= CFG_DATA_W'(len);
		@(posedge clk);
		cfg_index <= REG_NUM_ARMS;
		cfg_data <= CFG_DATA_W'(arms);
		@(posedge clk);
		cfg_we <= 1'b0;
		arm_len_m = len;
		arms_m = arms;
		n_settings++;
	endtask

	task automatic run_phase(input logic [ARM_LEN_W-1:0] len, input logic [NUM_ARMS_W-1:0] arms,
			input int count, input bit straight, input bit quiet);
		set_arm(len, arms);
		calm = quiet;
		repeat (count) send_joint(pick_angle(straight), 1'b0, '0);
		s_tvalid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			rx_hold <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
		end
	end

	always @(posedge clk) begin
		segment_t got;
		segment_t want;
		if (m_tvalid && m_tready) begin
			got.seg = m_tdata[SEG_W-1:0];
			got.sx = m_tdata[SX_LSB +: COORD_W];
			got.sy = m_tdata[SY_LSB +: COORD_W];
			got.ex = m_tdata[EX_LSB +: COORD_W];
			got.ey = m_tdata[EY_LSB +: COORD_W];
			got.last = m_tlast;
			n_results++;
			if (got.last) begin
				n_tips++;
			end
			if (pending_segments.size() == 0) begin
				report($sformatf("unexpected item: %s", fmt_segment(got)));
			end else begin
				want = pending_segments.pop_front();
				if (got !== want) begin
					report($sformatf("expected %s, got %s", fmt_segment(want), fmt_segment(got)));
				end
			end
		end
	end

	initial begin
		real r;
		real mag;
		for (int i = 0; i < ANGLE_STEPS; i++) begin
			r = 65536.0 * $sin(TWO_PI * i / ANGLE_STEPS);
			mag = $floor((r < 0.0 ? -r : r) + 0.5);
			sine_q16[i] = (r < 0.0) ? -$rtoi(mag) : $rtoi(mag);
		end
		arm_len_m = ARM_LENGTH_RESET;
		arms_m = NUM_ARMS_RESET;
		base_xm = 0;
		base_ym = 0;
		tip_xm = 0;
		tip_ym = 0;
		seg_next = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIR; i++) begin
			send_joint(dir_rows[i].angle, dir_rows[i].typed, dir_rows[i].want);
		end
		s_tvalid <= 1'b0;
		// The first and third phases end mid-arm so that the next, shorter arm starts past its end.
		run_phase(22'd2097152, 3'd6, 203, 1'b0, 1'b0);
		run_phase(22'd1500, 3'd1, 150, 1'b0, 1'b1);
		run_phase(22'h3FFFFF, 3'd7, 200, 1'b1, 1'b0);
		run_phase(22'd0, 3'd0, 100, 1'b0, 1'b0);
		for (int p = 0; p < 5; p++) begin
			run_phase(ARM_LEN_W'($urandom_range(0, 2097152)), NUM_ARMS_W'($urandom_range(1, 6)),
				190, p == 2, p % 2 == 1);
		end
		while (pending_segments.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d joint angles under %0d arm settings; checked %0d segments, %0d arm tips.",
			n_items, n_settings, n_results, n_tips);
		$display("Saturated segments: %0d. Mismatches: %0d. Still pending: %0d.",
			n_sat, n_errors, pending_segments.size());
		if (n_errors == 0 && pending_segments.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: sim.f
design/pafk_pkg.sv
design/pafk_rotate.sv
design/planar_arm_forward_kinematics.sv
test/planar_arm_forward_kinematics_tb.sv
